[sv/iir_transposed_direct_form_filter_top_assert.svh]
// assertion macros for the transposed direct form iir filter
`ifndef IIR_TRANSPOSED_DIRECT_FORM_FILTER_TOP_ASSERT_SVH
`define IIR_TRANSPOSED_DIRECT_FORM_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define IIR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define IIR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IIR_ASSERT(label, prop, msg)
`define IIR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[sv/iir_tdf_pkg.sv]
// shared types, constants and arithmetic helpers of the iir filter
package iir_tdf_pkg;

	localparam int TAPS        = 4;
	localparam int MAX_TAPS    = 4;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 32;
	localparam int STATE_BITS  = 48;
	localparam int PROD_SHIFT  = 12;
	localparam int OUT_SHIFT   = 16;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int TERM_BITS = PROD_BITS - PROD_SHIFT;
	// headroom for a three-operand sum
	localparam int ACC_BITS  = ((TERM_BITS > STATE_BITS) ? TERM_BITS : STATE_BITS) + 2;
	localparam int RND_BITS  = ACC_BITS - OUT_SHIFT;

	localparam int REG_IDX_BITS = 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [STATE_BITS-1:0]  state_t;
	typedef logic signed [TERM_BITS-1:0]   term_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_FF_COEF_0,
		REG_FF_COEF_1,
		REG_FF_COEF_2,
		REG_FF_COEF_3,
		REG_FB_COEF_1,
		REG_FB_COEF_2,
		REG_FB_COEF_3
	} reg_idx_t;

	localparam coef_t   FF0_RESET  = coef_t'(32'sh1000_0000);
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam state_t  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam state_t  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};

	// exact product, then floor shift to state grid
	function automatic term_t coef_term(input coef_t c, input sample_t v);
		logic signed [PROD_BITS-1:0] p;
		p = PROD_BITS'(c) * PROD_BITS'(v);
		return p[PROD_BITS-1:PROD_SHIFT];
	endfunction

endpackage

[sv/iir_tdf_if.sv]
// valid/ready channels carrying input and output sample words
interface iir_tdf_in_if;
	import iir_tdf_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface iir_tdf_out_if;
	import iir_tdf_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

[sv/iir_tdf_cell.sv]
// one delay cell: holds a state and updates it from its upstream neighbor
module iir_tdf_cell import iir_tdf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  logic   update,
	input  sample_t x,
	input  coef_t  ff_coef,
	input  coef_t  fb_coef,
	input  sample_t y,
	input  state_t s_next,
	output state_t s_q
);

	term_t ff_term_q;
	term_t fb_term;
	acc_t  sum;
	logic  in_range;

	always_ff @(posedge clk) begin
		if (load) begin
			ff_term_q <= coef_term(ff_coef, x);
		end
	end

	always_comb begin
		fb_term  = coef_term(fb_coef, y);
		sum      = ACC_BITS'(ff_term_q) + ACC_BITS'(s_next) - ACC_BITS'(fb_term);
		// top bits all equal the sign: fits the state width
		in_range = (&sum[ACC_BITS-1:STATE_BITS-1]) || !(|sum[ACC_BITS-1:STATE_BITS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else if (update) begin
			if (in_range) begin
				s_q <= sum[STATE_BITS-1:0];
			end else if (sum[ACC_BITS-1]) begin
				s_q <= STATE_MIN;
			end else begin
				s_q <= STATE_MAX;
			end
		end
	end

endmodule

[sv/iir_tdf_head.sv]
// output cell: b0 term plus first state, rounded and saturated
module iir_tdf_head import iir_tdf_pkg::*; (
	input  logic    clk,
	input  logic    load,
	input  sample_t x,
	input  coef_t   b0,
	input  state_t  s1,
	output sample_t y_q,
	output logic    clip_q
);

	acc_t                      full;
	acc_t                      rnd;
	logic signed [RND_BITS-1:0] q;
	logic                      in_range;

	always_comb begin
		full     = ACC_BITS'(coef_term(b0, x)) + ACC_BITS'(s1);
		// round half up onto the sample grid
		rnd      = full + ACC_BITS'(1 <<< (OUT_SHIFT - 1));
		q        = rnd[ACC_BITS-1:OUT_SHIFT];
		in_range = (&q[RND_BITS-1:SAMPLE_BITS-1]) || !(|q[RND_BITS-1:SAMPLE_BITS-1]);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			clip_q <= !in_range;
			if (in_range) begin
				y_q <= q[SAMPLE_BITS-1:0];
			end else if (q[RND_BITS-1]) begin
				y_q <= SAMPLE_MIN;
			end else begin
				y_q <= SAMPLE_MAX;
			end
		end
	end

endmodule

[sv/iir_transposed_direct_form_filter_top.sv]
// the result word is valid in the cycle after its word is accepted; no word is taken in
// the feedback step: the first step forms the output from b0*x and the first state, the
// second runs the a*y feedback through the cell chain. reset: states cleared to zero, b0
// = 1.0 and other coefficients zero, output empty. coefficients are written through the
// plain write port while the filter is idle; up to the user, not enforced by the block.
`include "iir_transposed_direct_form_filter_top_assert.svh"

module iir_transposed_direct_form_filter_top import iir_tdf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	iir_tdf_in_if.sink              smp_in,
	iir_tdf_out_if.source           smp_out,
	input  logic                    wr_en,
	input  logic [REG_IDX_BITS-1:0] wr_idx,
	input  logic [COEF_BITS-1:0]    wr_data
);

	// coefficient registers, fb_coef_q[i] holds a(i+1)
	coef_t ff_coef_q [MAX_TAPS];
	coef_t fb_coef_q [MAX_TAPS-1];

	logic    busy_q;       // feedback cycle of the current word
	logic    out_valid_q;  // result word waiting downstream
	logic    accept;
	sample_t y_q;
	logic    clip_q;

	// state chain, s_chain[i] is state s(i+1)
	state_t s_chain [TAPS-1];

	// config decode, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				ff_coef_q[i] <= (i == 0) ? FF0_RESET : '0;
			end
			for (int i = 0; i < MAX_TAPS - 1; i++) begin
				fb_coef_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_idx))
				REG_FF_COEF_0: ff_coef_q[0] <= wr_data;
				REG_FF_COEF_1: ff_coef_q[1] <= wr_data;
				REG_FF_COEF_2: ff_coef_q[2] <= wr_data;
				REG_FF_COEF_3: ff_coef_q[3] <= wr_data;
				REG_FB_COEF_1: fb_coef_q[0] <= wr_data;
				REG_FB_COEF_2: fb_coef_q[1] <= wr_data;
				REG_FB_COEF_3: fb_coef_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	// take a word when not in feedback and the output slot frees up
	assign smp_in.ready = !busy_q && (!out_valid_q || smp_out.ready);
	assign accept       = smp_in.valid && smp_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q <= accept;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (smp_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register doubles as the y fed back: it cannot reload during the feedback cycle
	iir_tdf_head u_head (
		.clk    (clk),
		.load   (accept),
		.x      (smp_in.sample_in),
		.b0     (ff_coef_q[0]),
		.s1     (s_chain[0]),
		.y_q    (y_q),
		.clip_q (clip_q)
	);

	// each cell takes the old state of its upstream neighbor, the last one takes zero
	for (genvar i = 0; i < TAPS - 1; i++) begin : g_cell
		state_t s_next;
		if (i == TAPS - 2) begin : g_last
			assign s_next = '0;
		end else begin : g_mid
			assign s_next = s_chain[i+1];
		end

		iir_tdf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (accept),
			.update  (busy_q),
			.x       (smp_in.sample_in),
			.ff_coef (ff_coef_q[i+1]),
			.fb_coef (fb_coef_q[i]),
			.y       (y_q),
			.s_next  (s_next),
			.s_q     (s_chain[i])
		);
	end

	assign smp_out.valid      = out_valid_q;
	assign smp_out.sample_out = y_q;
	assign smp_out.clipped    = clip_q;

	`IIR_ASSERT(a_busy_after_accept, accept |=> busy_q, "feedback cycle missing after accept")
	`IIR_ASSERT(a_busy_one_cycle, busy_q |=> !busy_q, "feedback lasted more than one cycle")
	`IIR_ASSERT_ALWAYS(a_no_take_when_busy, busy_q |-> !smp_in.ready, "word taken during feedback")
	`IIR_ASSERT(a_result_after_accept, accept |=> out_valid_q, "no result word after accept")
	`IIR_ASSERT(a_clip_at_rail, (out_valid_q && clip_q) |-> (y_q == SAMPLE_MAX || y_q == SAMPLE_MIN), "clipped word not at a rail")

endmodule

[test/tb_top.sv]
// self-checking testbench for the transposed direct form iir filter top level
module tb_top;
	import iir_tdf_pkg::*;

	// quiet cycles tolerated before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// cycles left for the feedback pass to settle before a coefficient write
	localparam int SETTLE_CYCLES = 4;
	// cycles allowed after the last word for stray output
	localparam int DRAIN_CYCLES = 8;
	localparam int N_PHASES = 15;
	localparam int WORDS_PER_PHASE = 72;
	localparam int N_DIR = 29;

	// index past the last coefficient, writes there must be ignored
	localparam logic [REG_IDX_BITS-1:0] REG_IDX_SPARE = 3'd7;
	localparam coef_t COEF_MAX = 32'sh7fff_ffff;
	localparam coef_t COEF_MIN = 32'sh8000_0000;

	typedef enum logic {ROW_WR, ROW_SMP} row_kind_t;

	// one line of the directed table: a coefficient write or a sample word
	typedef struct packed {
		row_kind_t                 kind;
		logic [REG_IDX_BITS-1:0]   idx;
		coef_t                     data;
		sample_t                   smp;
		logic                      known;
		sample_t                   exp_out;
		logic                      exp_clip;
	} dir_row_t;

	typedef struct {
		sample_t smp;
		logic    clip;
	} out_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                    wr_en = 1'b0;
	logic [REG_IDX_BITS-1:0] wr_idx = '0;
	logic [COEF_BITS-1:0]    wr_data = '0;

	iir_tdf_in_if  in_ch();
	iir_tdf_out_if out_ch();

	// filter image kept by the testbench: coefficients and delay line
	coef_t  ff_gain [MAX_TAPS];
	coef_t  fb_gain [MAX_TAPS];
	state_t taps    [MAX_TAPS-1];

	// filtered words still owed by the block, oldest first
	out_word_t out_word_q[$];

	int unsigned err_cnt = 0;
	int unsigned quiet_cycles = 0;
	bit in_burst = 1'b0;
	bit out_burst = 1'b0;

	dir_row_t dir_rows [N_DIR];

	iir_transposed_direct_form_filter_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp_in  (in_ch),
		.smp_out (out_ch),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// coefficient times value, exact, then floor onto the state grid
	function automatic longint scaled(coef_t c, longint v);
		return (longint'(c) * v) >>> PROD_SHIFT;
	endfunction

	function automatic state_t sat_state(longint s);
		if (s > longint'(STATE_MAX))
			return STATE_MAX;
		if (s < longint'(STATE_MIN))
			return STATE_MIN;
		return state_t'(s);
	endfunction

	// one sample through the filter image: output word, then the new delay line
	function automatic void filter_predict(input sample_t x, output sample_t y,
			output logic clip);
		longint full;
		longint yr;
		longint s;
		full = scaled(ff_gain[0], longint'(x)) + longint'(taps[0]);
		// round half up onto the sample grid
		yr = (full + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		clip = 1'b0;
		if (yr > longint'(SAMPLE_MAX)) begin
			yr = longint'(SAMPLE_MAX);
			clip = 1'b1;
		end else if (yr < longint'(SAMPLE_MIN)) begin
			yr = longint'(SAMPLE_MIN);
			clip = 1'b1;
		end
		y = sample_t'(yr);
		// feedback uses the saturated output
		for (int n = 1; n < TAPS - 1; n++) begin
			s = scaled(ff_gain[n], longint'(x)) + longint'(taps[n])
				- scaled(fb_gain[n], longint'(y));
			taps[n-1] = sat_state(s);
		end
		s = scaled(ff_gain[TAPS-1], longint'(x)) - scaled(fb_gain[TAPS-1], longint'(y));
		taps[TAPS-2] = sat_state(s);
	endfunction

	function automatic coef_t rand_coef(int unsigned span);
		return coef_t'(int'($urandom_range(0, 2 * span)) - int'(span));
	endfunction

	function automatic sample_t draw_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return sample_t'(int'($urandom_range(0, 8192)) - 4096);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// write one coefficient once the filter has gone quiet
	task automatic write_coef(logic [REG_IDX_BITS-1:0] idx, coef_t val);
		in_ch.valid <= 1'b0;
		while (out_word_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		// mirror the write in the filter image
		case (idx)
			REG_FF_COEF_0: ff_gain[0] = val;
			REG_FF_COEF_1: ff_gain[1] = val;
			REG_FF_COEF_2: ff_gain[2] = val;
			REG_FF_COEF_3: ff_gain[3] = val;
			REG_FB_COEF_1: fb_gain[1] = val;
			REG_FB_COEF_2: fb_gain[2] = val;
			REG_FB_COEF_3: fb_gain[3] = val;
			default: ;
		endcase
	endtask

	// hand one sample word over, then log what should come back for it
	task automatic send_word(sample_t x, logic known, sample_t typed_out, logic typed_clip);
		int unsigned gap;
		sample_t y;
		logic clip;
		gap = in_burst ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= x;
		do @(posedge clk); while (!in_ch.ready);
		// the image always advances, even where the answer is typed in
		filter_predict(x, y, clip);
		if (known) begin
			y = typed_out;
			clip = typed_clip;
		end
		out_word_q.push_back('{smp: y, clip: clip});
	endtask

	// output side: random back-pressure, every accepted word is checked
	initial begin
		out_word_t want;
		int unsigned stall;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_burst = !out_burst;
			stall = out_burst ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (out_word_q.size() == 0) begin
				$error("unexpected output word: sample_out %0d clipped %0b",
					out_ch.sample_out, out_ch.clipped);
				err_cnt++;
			end else begin
				want = out_word_q.pop_front();
				if (out_ch.sample_out !== want.smp) begin
					$error("sample_out: expected %0d, got %0d", want.smp, out_ch.sample_out);
					err_cnt++;
				end
				if (out_ch.clipped !== want.clip) begin
					$error("clipped: expected %0b, got %0b", want.clip, out_ch.clipped);
					err_cnt++;
				end
			end
		end
	end

	// hang detector: any handshake or write counts as progress
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned kind;
		coef_t v;
		// falling edge at time zero so the asynchronous reset takes hold
		arst_n <= 1'b0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;

		// image after reset: b0 = 1.0, everything else cleared
		for (int i = 0; i < MAX_TAPS; i++) begin
			ff_gain[i] = '0;
			fb_gain[i] = '0;
		end
		ff_gain[0] = FF0_RESET;
		for (int i = 0; i < MAX_TAPS - 1; i++)
			taps[i] = '0;

		// directed table; typed answers only where they are obvious
		dir_rows = '{
			// reset filter is a straight wire
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd0, 1'b1, 24'sd0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, -24'sd1, 1'b1, -24'sd1, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd1, 1'b1, 24'sd1, 1'b0},
			// largest positive gain saturates both rails
			'{ROW_WR, REG_FF_COEF_0, COEF_MAX, '0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b1},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b1},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd0, 1'b1, 24'sd0, 1'b0},
			// largest negative gain flips the rails
			'{ROW_WR, REG_FF_COEF_0, COEF_MIN, '0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MAX, 1'b1, SAMPLE_MIN, 1'b1},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MIN, 1'b1, SAMPLE_MAX, 1'b1},
			// write past the last register, nothing may change
			'{ROW_WR, REG_IDX_SPARE, 32'sh1234_5678, '0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd1, 1'b0, '0, 1'b0},
			// full third-order filter with a hard feedback tap
			'{ROW_WR, REG_FF_COEF_0, FF0_RESET, '0, 1'b0, '0, 1'b0},
			'{ROW_WR, REG_FF_COEF_1, 32'sh0800_0000, '0, 1'b0, '0, 1'b0},
			'{ROW_WR, REG_FF_COEF_2, -32'sh1000_0000, '0, 1'b0, '0, 1'b0},
			'{ROW_WR, REG_FF_COEF_3, 32'sh0400_0000, '0, 1'b0, '0, 1'b0},
			'{ROW_WR, REG_FB_COEF_1, -32'sh0800_0000, '0, 1'b0, '0, 1'b0},
			'{ROW_WR, REG_FB_COEF_2, 32'sh0200_0000, '0, 1'b0, '0, 1'b0},
			'{ROW_WR, REG_FB_COEF_3, COEF_MAX, '0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sh40_0000, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MAX, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, SAMPLE_MIN, 1'b0, '0, 1'b0},
			// ring-out on silence
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd0, 1'b0, '0, 1'b0},
			'{ROW_SMP, REG_FF_COEF_0, '0, 24'sd1, 1'b0, '0, 1'b0}
		};

		// single reset at the start
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			if (dir_rows[r].kind == ROW_WR)
				write_coef(dir_rows[r].idx, dir_rows[r].data);
			else
				send_word(dir_rows[r].smp, dir_rows[r].known, dir_rows[r].exp_out,
					dir_rows[r].exp_clip);
		end

		// random phases, each with its own coefficient set
		for (int ph = 0; ph < N_PHASES; ph++) begin
			kind = ph % 5;
			for (int r = 0; r <= REG_FB_COEF_3; r++) begin
				case (kind)
					// anything goes, mostly saturating
					0: v = coef_t'($urandom);
					// stable: unity-range numerator, weak feedback
					1: v = (r <= REG_FF_COEF_3) ? rand_coef(1 << 28) : rand_coef(1 << 25);
					// register extremes and unit gains
					2: begin
						case ($urandom_range(0, 4))
							0: v = COEF_MAX;
							1: v = COEF_MIN;
							2: v = '0;
							3: v = FF0_RESET;
							default: v = -FF0_RESET;
						endcase
					end
					// plain fir around a unit leading tap
					3: begin
						if (r == REG_FF_COEF_0)
							v = FF0_RESET;
						else
							v = (r <= REG_FF_COEF_3) ? rand_coef(1 << 27) : '0;
					end
					// hot numerator, weak feedback, clips now and then
					default: v = (r <= REG_FF_COEF_3) ? rand_coef(1 << 30) : rand_coef(1 << 25);
				endcase
				write_coef(r[REG_IDX_BITS-1:0], v);
			end
			if ($urandom_range(0, 3) == 0)
				write_coef(REG_IDX_SPARE, coef_t'($urandom));
			in_burst = (ph % 4 == 3);
			for (int k = 0; k < WORDS_PER_PHASE; k++)
				send_word(draw_sample(), 1'b0, '0, 1'b0);
		end

		in_ch.valid <= 1'b0;
		while (out_word_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/iir_tdf_pkg.sv
sv/iir_tdf_if.sv
sv/iir_tdf_cell.sv
sv/iir_tdf_head.sv
sv/iir_transposed_direct_form_filter_top.sv
test/tb_top.sv
